[hw/rtl/pdb_pkg.sv]
// Package for the principled diffuse shading unit: item types, register
// indexes and fixed-point constants. No dependencies.
package pdb_pkg;

    // One input item: Q2.14 vectors and a Q8.8 base color
    typedef struct packed {
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        colour_r;
        logic [15:0]        colour_g;
        logic [15:0]        colour_b;
    } sample_t;

    // One result item: Q8.8 shaded color and the clip flag
    typedef struct packed {
        logic [15:0] shade_r;
        logic [15:0] shade_g;
        logic [15:0] shade_b;
        logic        saturated;
    } shade_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_ROUGHNESS  = 1'b0,
        CFG_SUBSURFACE = 1'b1
    } cfg_idx_t;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [15:0] HALF_Q16    = 16'd32768;
    localparam logic [16:0] ONE25_Q16   = 17'd81920;
    localparam logic [30:0] INV_PI_Q32  = 31'd1367130551;
    localparam logic [34:0] K_CAP       = 35'h4_0000_0000;
    localparam logic [15:0] ROUGH_RESET = 16'd32768;

endpackage

[hw/rtl/pdb_isqrt.sv]
// Pipelined floor square root, one result bit per register stage.
// No dependencies.
module pdb_isqrt #(
    parameter int IN_W = 34
) (
    input  logic                clk,
    input  logic [IN_W-1:0]     rad,
    output logic [IN_W/2-1:0]   root
);
    localparam int OW = IN_W / 2;
    localparam int RW = OW + 2;

    logic [IN_W-1:0] rad_reg  [OW];
    logic [RW-1:0]   rem_reg  [OW];
    logic [OW-1:0]   root_reg [OW];

    genvar k;
    generate
        for (k = 0; k < OW; k++)
        begin : g_stage
            logic [IN_W-1:0] rad_p;
            logic [RW-1:0]   rem_p;
            logic [OW-1:0]   root_p;
            logic [RW-1:0]   rem_sh;
            logic [RW-1:0]   trial;

            if (k == 0)
            begin : g_first
                assign rad_p  = rad;
                assign rem_p  = '0;
                assign root_p = '0;
            end
            else
            begin : g_next
                assign rad_p  = rad_reg[k-1];
                assign rem_p  = rem_reg[k-1];
                assign root_p = root_reg[k-1];
            end

            // bring down the next bit pair, try 4*root+1
            assign rem_sh = {rem_p[RW-3:0], rad_p[IN_W-1 -: 2]};
            assign trial  = {root_p, 2'b01};

            always_ff @(posedge clk)
            begin
                rad_reg[k] <= rad_p << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_p[OW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_p[OW-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign root = root_reg[OW-1];

endmodule

[hw/rtl/pdb_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Flags quotients that do not fit in QW bits. No dependencies.
module pdb_div #(
    parameter int NW = 35,
    parameter int DW = 17,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quo,
    output logic          ovf
);
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] bits_reg [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] dv_reg   [QW];
    logic          ovf_reg  [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [DW-1:0] rem_p;
            logic [QW-1:0] bits_p;
            logic [QW-1:0] quo_p;
            logic [DW-1:0] dv_p;
            logic          ovf_p;
            logic [DW:0]   rem_sh;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                logic [NW-QW-1:0] hi;
                assign hi     = dividend[NW-1:QW];
                assign rem_p  = DW'(hi);
                assign bits_p = dividend[QW-1:0];
                assign quo_p  = '0;
                assign dv_p   = divisor;
                assign ovf_p  = (hi >= divisor);
            end
            else
            begin : g_next
                assign rem_p  = rem_reg[k-1];
                assign bits_p = bits_reg[k-1];
                assign quo_p  = quo_reg[k-1];
                assign dv_p   = dv_reg[k-1];
                assign ovf_p  = ovf_reg[k-1];
            end

            // shift in the next dividend bit and try a subtract
            assign rem_sh = {rem_p, bits_p[QW-1]};
            assign diff   = rem_sh - {1'b0, dv_p};
            assign ge     = (rem_sh >= {1'b0, dv_p});

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                bits_reg[k] <= bits_p << 1;
                if (QW > 1)
                    quo_reg[k] <= {quo_p[QW-2:0], ge};
                else
                    quo_reg[k] <= QW'(ge);
                dv_reg[k]   <= dv_p;
                ovf_reg[k]  <= ovf_p;
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];
    assign ovf = ovf_reg[QW-1];

endmodule

[hw/rtl/principled_diffuse_brdf_unit.sv]
// Principled diffuse shading unit: top level, fixed-point pipeline.
// Throughput: one item per cycle; busy is never raised. Items pass the
// 17-stage square root, the 17-stage half-vector divide and the
// multiplier chain that follows, and done is raised with each result.
// Reset clears the valid pipe and loads roughness 0.5, subsurface
// weight 0; the receiver cannot stall.
// Depends on pdb_pkg, pdb_isqrt and pdb_div.
module principled_diffuse_brdf_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pdb_pkg::sample_t  sample,
    output logic              done,
    output pdb_pkg::shade_t   shade,
    input  logic              cfg_we,
    input  pdb_pkg::cfg_idx_t cfg_addr,
    input  logic [15:0]       cfg_wdata
);
    import pdb_pkg::*;

    localparam int NSTG   = 50;
    localparam int SB_LEN = 46;
    localparam int TAP_DIV  = 16;  // stage 20
    localparam int TAP_COS  = 33;  // stage 37
    localparam int TAP_KB   = 38;  // stage 42
    localparam int TAP_KS   = 39;  // stage 43
    localparam int TAP_COL  = 43;  // stage 47
    localparam int TAP_ZERO = 45;  // stage 49
    localparam int TERM_LEN = 6;

    typedef struct packed {
        logic             zero;
        logic [16:0]      cin;
        logic [16:0]      cout;
        logic [34:0]      num;
        logic [2:0][15:0] col;
    } sb_t;

    function automatic logic [16:0] cos_of(input logic signed [33:0] d);
        logic [33:0] mag;
        logic [34:0] rnd;
        logic [22:0] c;
        begin
            mag = d[33] ? 34'(-d) : 34'(d);
            rnd = 35'(mag) + 35'd2048;
            c   = rnd[34:12];
            cos_of = (c > 23'(ONE_Q16)) ? ONE_Q16 : c[16:0];
        end
    endfunction

    // configuration registers
    logic [15:0] rough_reg;
    logic [15:0] subs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rough_reg <= ROUGH_RESET;
            subs_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ROUGHNESS:  rough_reg <= cfg_wdata;
                CFG_SUBSURFACE: subs_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // valid bits travel alongside the data
    logic accept;
    logic [NSTG-1:0] vld_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NSTG-2:0], accept};
    end

    // stage 1: half vector, normal dot-product terms
    logic signed [15:0] lv [3];
    logic signed [15:0] vv [3];
    logic signed [15:0] nv [3];
    logic signed [16:0] h1_reg   [3];
    logic signed [15:0] v1_reg   [3];
    logic signed [31:0] pnl1_reg [3];
    logic signed [31:0] pnv1_reg [3];
    logic [2:0][15:0]   col1_reg;

    assign lv[0] = sample.light_x;
    assign lv[1] = sample.light_y;
    assign lv[2] = sample.light_z;
    assign vv[0] = sample.view_x;
    assign vv[1] = sample.view_y;
    assign vv[2] = sample.view_z;
    assign nv[0] = sample.normal_x;
    assign nv[1] = sample.normal_y;
    assign nv[2] = sample.normal_z;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            h1_reg[i]   <= 17'(lv[i]) + 17'(vv[i]);
            v1_reg[i]   <= vv[i];
            pnl1_reg[i] <= 32'(nv[i]) * 32'(lv[i]);
            pnv1_reg[i] <= 32'(nv[i]) * 32'(vv[i]);
        end
        col1_reg <= {sample.colour_b, sample.colour_g, sample.colour_r};
    end

    // stage 2: half-vector squares and dot with view, cosine sums
    logic [32:0]        sq2_reg  [3];
    logic signed [33:0] phv2_reg [3];
    logic signed [33:0] dnl2_reg;
    logic signed [33:0] dnv2_reg;
    logic [2:0][15:0]   col2_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i]  <= 33'(34'(h1_reg[i]) * 34'(h1_reg[i]));
            phv2_reg[i] <= 34'(h1_reg[i]) * 34'(v1_reg[i]);
        end
        dnl2_reg <= 34'(pnl1_reg[0]) + 34'(pnl1_reg[1]) + 34'(pnl1_reg[2]);
        dnv2_reg <= 34'(pnv1_reg[0]) + 34'(pnv1_reg[1]) + 34'(pnv1_reg[2]);
        col2_reg <= col1_reg;
    end

    // stage 3: squared length, clamped cosines
    logic [33:0]        hh3_reg;
    logic signed [34:0] dhv3_reg;
    logic [16:0]        cin3_reg;
    logic [16:0]        cout3_reg;
    logic [2:0][15:0]   col3_reg;

    always_ff @(posedge clk)
    begin
        hh3_reg   <= 34'(sq2_reg[0]) + 34'(sq2_reg[1]) + 34'(sq2_reg[2]);
        dhv3_reg  <= 35'(phv2_reg[0]) + 35'(phv2_reg[1]) + 35'(phv2_reg[2]);
        cin3_reg  <= cos_of(dnl2_reg);
        cout3_reg <= cos_of(dnv2_reg);
        col3_reg  <= col2_reg;
    end

    // sideband line from stage 4 on
    logic [17:0]        sum3;
    logic signed [34:0] dhv_mag;
    sb_t                sb_next;
    sb_t                sb_reg [SB_LEN];

    assign sum3    = 18'(cin3_reg) + 18'(cout3_reg);
    assign dhv_mag = dhv3_reg[34] ? -dhv3_reg : dhv3_reg;

    always_comb
    begin
        sb_next.zero = (hh3_reg == '0) || (sum3 == '0);
        sb_next.cin  = cin3_reg;
        sb_next.cout = cout3_reg;
        sb_next.num  = {dhv_mag[32:0], 2'b00};
        sb_next.col  = col3_reg;
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0] <= sb_next;
        for (int i = 1; i < SB_LEN; i++)
            sb_reg[i] <= sb_reg[i-1];
    end

    // half-vector length, stages 4..20
    logic [16:0] hlen;

    pdb_isqrt #(
        .IN_W (34)
    ) u_isqrt (
        .clk  (clk),
        .rad  (hh3_reg),
        .root (hlen)
    );

    // |dot(H,V)|*4 / |H|, stages 21..37
    logic [16:0] hq;
    logic        hq_ovf;

    pdb_div #(
        .NW (35),
        .DW (17),
        .QW (17)
    ) u_hdiv (
        .clk      (clk),
        .dividend (sb_reg[TAP_DIV].num),
        .divisor  (hlen),
        .quo      (hq),
        .ovf      (hq_ovf)
    );

    // rounded reciprocal of the cosine sum, stages 4..36
    logic [33:0] rcp_dividend;
    logic [32:0] inv;
    logic        inv_ovf;

    assign rcp_dividend = 34'h1_0000_0000 + 34'(sum3 >> 1);

    pdb_div #(
        .NW (34),
        .DW (18),
        .QW (33)
    ) u_rdiv (
        .clk      (clk),
        .dividend (rcp_dividend),
        .divisor  (sum3),
        .quo      (inv),
        .ovf      (inv_ovf)
    );

    logic [32:0] term_reg [TERM_LEN];

    always_ff @(posedge clk)
    begin
        // the dividend is below 2^33, so only a zero cosine sum flags overflow
        term_reg[0] <= inv_ovf ? '1 : inv - 33'(HALF_Q16);
        for (int i = 1; i < TERM_LEN; i++)
            term_reg[i] <= term_reg[i-1];
    end

    // stage 38: hout squared, 1-cos squared
    logic [16:0] hout;
    logic [16:0] tin;
    logic [16:0] tout;
    logic [34:0] m_hh;
    logic [34:0] m_t2i;
    logic [34:0] m_t2o;
    logic [16:0] hh2_reg;
    logic [16:0] tin_reg;
    logic [16:0] tout_reg;
    logic [16:0] t2i_reg;
    logic [16:0] t2o_reg;

    always_comb
    begin
        hout  = (hq_ovf || hq > ONE_Q16) ? ONE_Q16 : hq;
        tin   = ONE_Q16 - sb_reg[TAP_COS].cin;
        tout  = ONE_Q16 - sb_reg[TAP_COS].cout;
        m_hh  = 35'(hout) * 35'(hout) + 35'(HALF_Q16);
        m_t2i = 35'(tin) * 35'(tin) + 35'(HALF_Q16);
        m_t2o = 35'(tout) * 35'(tout) + 35'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        hh2_reg  <= 17'(m_hh >> 16);
        tin_reg  <= tin;
        tout_reg <= tout;
        t2i_reg  <= 17'(m_t2i >> 16);
        t2o_reg  <= 17'(m_t2o >> 16);
    end

    // stage 39: roughness term, fourth powers
    logic [34:0] m_rh;
    logic [34:0] m_t4i;
    logic [34:0] m_t4o;
    logic [16:0] rh39_reg;
    logic [16:0] tin39_reg;
    logic [16:0] tout39_reg;
    logic [16:0] t4i_reg;
    logic [16:0] t4o_reg;

    always_comb
    begin
        m_rh  = 35'(rough_reg) * 35'(hh2_reg) + 35'(HALF_Q16);
        m_t4i = 35'(t2i_reg) * 35'(t2i_reg) + 35'(HALF_Q16);
        m_t4o = 35'(t2o_reg) * 35'(t2o_reg) + 35'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        rh39_reg   <= 17'(m_rh >> 16);
        tin39_reg  <= tin_reg;
        tout39_reg <= tout_reg;
        t4i_reg    <= 17'(m_t4i >> 16);
        t4o_reg    <= 17'(m_t4o >> 16);
    end

    // stage 40: fifth powers
    logic [34:0] m_pi;
    logic [34:0] m_po;
    logic [16:0] rh40_reg;
    logic [16:0] pin_reg;
    logic [16:0] pout_reg;

    always_comb
    begin
        m_pi = 35'(t4i_reg) * 35'(tin39_reg) + 35'(HALF_Q16);
        m_po = 35'(t4o_reg) * 35'(tout39_reg) + 35'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        rh40_reg <= rh39_reg;
        pin_reg  <= 17'(m_pi >> 16);
        pout_reg <= 17'(m_po >> 16);
    end

    // stage 41: diffuse and subsurface Fresnel factors
    logic [35:0] m_ai;
    logic [35:0] m_ao;
    logic [34:0] m_bi;
    logic [34:0] m_bo;
    logic [19:0] fd_in_next;
    logic [19:0] fd_out_next;
    logic [18:0] fss_in_next;
    logic [18:0] fss_out_next;
    logic [19:0] fd_in_reg;
    logic [19:0] fd_out_reg;
    logic [18:0] fss_in_reg;
    logic [18:0] fss_out_reg;

    always_comb
    begin
        m_ai = 36'({rh40_reg, 1'b0}) * 36'(pin_reg) + 36'(HALF_Q16);
        m_ao = 36'({rh40_reg, 1'b0}) * 36'(pout_reg) + 36'(HALF_Q16);
        m_bi = 35'(rh40_reg) * 35'(pin_reg) + 35'(HALF_Q16);
        m_bo = 35'(rh40_reg) * 35'(pout_reg) + 35'(HALF_Q16);
        fd_in_next   = 20'(ONE_Q16) + 20'(m_ai >> 16)
                     - 20'((18'(pin_reg) + 18'd1) >> 1);
        fd_out_next  = 20'(ONE_Q16) + 20'(m_ao >> 16)
                     - 20'((18'(pout_reg) + 18'd1) >> 1);
        fss_in_next  = 19'(ONE_Q16) + 19'(m_bi >> 16) - 19'(pin_reg);
        fss_out_next = 19'(ONE_Q16) + 19'(m_bo >> 16) - 19'(pout_reg);
    end

    always_ff @(posedge clk)
    begin
        fd_in_reg   <= fd_in_next;
        fd_out_reg  <= fd_out_next;
        fss_in_reg  <= fss_in_next;
        fss_out_reg <= fss_out_next;
    end

    // stage 42: products of the in and out factors
    logic [40:0] m_fdp;
    logic [38:0] m_fssp;
    logic [24:0] fdp_reg;
    logic [22:0] fssp_reg;

    always_comb
    begin
        m_fdp  = 41'(fd_in_reg) * 41'(fd_out_reg) + 41'(HALF_Q16);
        m_fssp = 39'(fss_in_reg) * 39'(fss_out_reg) + 39'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        fdp_reg  <= 25'(m_fdp >> 16);
        fssp_reg <= 23'(m_fssp >> 16);
    end

    // stage 43: base term, subsurface term times (1/sum - 0.5)
    logic [42:0] m_kb;
    logic [56:0] m_st;
    logic [26:0] kb43_reg;
    logic [41:0] st_reg;

    always_comb
    begin
        m_kb = 43'(fdp_reg) * 43'(sb_reg[TAP_KB].cout) + 43'(HALF_Q16);
        m_st = 57'(fssp_reg) * 57'(term_reg[TERM_LEN-1]) + 57'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        kb43_reg <= 27'(m_kb >> 16);
        st_reg   <= 42'(m_st >> 16) + 42'(HALF_Q16);
    end

    // stage 44: times cos out
    logic [59:0] m_ks1;
    logic [26:0] kb44_reg;
    logic [43:0] ks1_reg;

    assign m_ks1 = 60'(st_reg) * 60'(sb_reg[TAP_KS].cout) + 60'(HALF_Q16);

    always_ff @(posedge clk)
    begin
        kb44_reg <= kb43_reg;
        ks1_reg  <= 44'(m_ks1 >> 16);
    end

    // stage 45: subsurface scale of 1.25
    logic [61:0] m_ks;
    logic [26:0] kb45_reg;
    logic [45:0] ks_reg;

    assign m_ks = 62'(ks1_reg) * 62'(ONE25_Q16) + 62'(HALF_Q16);

    always_ff @(posedge clk)
    begin
        kb45_reg <= kb44_reg;
        ks_reg   <= 46'(m_ks >> 16);
    end

    // stage 46: blend weights
    logic [44:0] m_ma;
    logic [62:0] m_mb;
    logic [28:0] ma_reg;
    logic [46:0] mb_reg;

    always_comb
    begin
        m_ma = 45'(kb45_reg) * 45'(ONE_Q16 - 17'(subs_reg)) + 45'(HALF_Q16);
        m_mb = 63'(ks_reg) * 63'(subs_reg) + 63'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= 29'(m_ma >> 16);
        mb_reg <= 47'(m_mb >> 16);
    end

    // stage 47: blended scalar, capped
    logic [47:0] ksum;
    logic [34:0] k_reg;

    assign ksum = 48'(ma_reg) + 48'(mb_reg);

    always_ff @(posedge clk)
    begin
        k_reg <= (ksum > 48'(K_CAP)) ? K_CAP : ksum[34:0];
    end

    // stage 48: color times scalar
    logic [50:0] pc_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            pc_reg[i] <= 51'(sb_reg[TAP_COL].col[i]) * 51'(k_reg);
    end

    // stage 49: split product times 1/pi
    logic [57:0] hi_reg [3];
    logic [30:0] lo_reg [3];
    logic [54:0] m_lo   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            m_lo[i] = 55'(pc_reg[i][23:0]) * 55'(INV_PI_Q32);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            hi_reg[i] <= 58'(pc_reg[i][50:24]) * 58'(INV_PI_Q32);
            lo_reg[i] <= 31'(m_lo[i] >> 24);
        end
    end

    // stage 50: round, saturate, output register
    logic [58:0] xs   [3];
    logic [34:0] rr   [3];
    logic [15:0] ch   [3];
    logic [2:0]  clip;
    shade_t      shade_next;
    shade_t      shade_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xs[i]   = 59'(hi_reg[i]) + 59'(lo_reg[i]) + 59'h80_0000;
            rr[i]   = 35'(xs[i] >> 24);
            clip[i] = (rr[i] > 35'hFFFF);
            ch[i]   = clip[i] ? 16'hFFFF : rr[i][15:0];
        end
        if (sb_reg[TAP_ZERO].zero)
        begin
            shade_next.shade_r   = 16'hFFFF;
            shade_next.shade_g   = 16'hFFFF;
            shade_next.shade_b   = 16'hFFFF;
            shade_next.saturated = 1'b1;
        end
        else
        begin
            shade_next.shade_r   = ch[0];
            shade_next.shade_g   = ch[1];
            shade_next.shade_b   = ch[2];
            shade_next.saturated = |clip;
        end
    end

    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
    end

    assign shade = shade_reg;
    assign done  = vld_reg[NSTG-1];

endmodule
